FILE: design/mce_pkg.sv
`timescale 1ns / 1ps
// Package of the Morse character encoder: field widths, element lengths,
// sequencer states and the Morse code table with its lookup function.
// Depends on nothing.
package mce_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned SYM_W = 5;
	localparam int unsigned MCE_FIFO_DEPTH = 4;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

	localparam logic [LEN_W-1:0] LEN_DOT = 3'd1;
	localparam logic [LEN_W-1:0] LEN_DASH = 3'd3;
	localparam logic [LEN_W-1:0] LEN_SYM_GAP = 3'd1;
	localparam logic [LEN_W-1:0] LEN_LETTER_GAP = 3'd3;
	localparam logic [LEN_W-1:0] LEN_WORD_GAP = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPACE,
		ST_MARK,
		ST_GAP,
		ST_LETTER,
		ST_WORD
	} mce_state_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] bits;
	} mce_code_t;

	// Symbols are stored left-aligned: the first symbol is the top bit, a dash is a one.
	localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;
	localparam logic [SYM_W-1:0] DIGIT_BITS [0:9] = '{
		5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
		5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
	};

	localparam logic [SYM_W-1:0] LETTER_BITS [0:25] = '{
		5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100, 5'b11000,
		5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000, 5'b11000, 5'b10000,
		5'b11100, 5'b01100, 5'b11010, 5'b01000, 5'b00000, 5'b10000, 5'b00100,
		5'b00010, 5'b01100, 5'b10010, 5'b10110, 5'b11000
	};

	localparam logic [LEN_W-1:0] LETTER_LEN [0:25] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
		3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
		3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3,
		3'd4, 3'd3, 3'd4, 3'd4, 3'd4
	};

	function automatic mce_code_t mce_lookup(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] ofs;
		mce_code_t code;
		code = '{len: '0, bits: '0};
		ofs = '0;
		if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
			ofs = ch - CHAR_ZERO;
			code.len = DIGIT_LEN;
			code.bits = DIGIT_BITS[ofs[3:0]];
		end else if (ch inside {[CHAR_A:CHAR_Z]}) begin
			ofs = ch - CHAR_A;
			code.len = LETTER_LEN[ofs[4:0]];
			code.bits = LETTER_BITS[ofs[4:0]];
		end
		return code;
	endfunction

endpackage

FILE: design/mce_in_if.sv
`timescale 1ns / 1ps
// Character channel of the Morse character encoder: valid, ready and one
// character item. Depends on mce_pkg.
interface mce_in_if import mce_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] character;
	logic end_of_phrase;

	modport source (output valid, output character, output end_of_phrase, input ready);
	modport sink (input valid, input character, input end_of_phrase, output ready);
endinterface

FILE: design/mce_out_if.sv
`timescale 1ns / 1ps
// Keying element channel of the Morse character encoder: valid, ready and
// one element item. Depends on mce_pkg.
interface mce_out_if import mce_pkg::*; ();
	logic valid;
	logic ready;
	logic key_down;
	logic [LEN_W-1:0] length_units;
	logic last_of_run;

	modport source (output valid, output key_down, output length_units, output last_of_run,
		input ready);
	modport sink (input valid, input key_down, input length_units, input last_of_run,
		output ready);
endinterface

FILE: design/mce_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mce_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/morse_character_encoder_unit.sv
`timescale 1ns / 1ps
// Morse character encoder: characters queue in a RAM and a sequencer turns each
// into keying elements. Depends on mce_pkg, mce_in_if, mce_out_if and mce_ram.
// The first element of an item passes the RAM read register, the sequencer state and the output register.
// Throughput: one element per cycle while the output is not stalled; an item gives 1 to 12 elements,
// and the next queued item follows with no gap.
// Reset clears pointers, counts, the sequencer and the output valid; the RAM keeps no reset.
module morse_character_encoder_unit import mce_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = MCE_FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	mce_in_if.sink chars,
	mce_out_if.source elements
);

	localparam int unsigned AW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned EW = CHAR_W + 1;

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic pend_q;
	logic wr_en;
	logic rd_en;
	logic load;
	logic [EW-1:0] rdata;
	logic [CHAR_W-1:0] rd_char;
	logic rd_eop;
	mce_code_t rd_code;

	mce_state_t state_q;
	mce_state_t state_d;
	logic [2:0] idx_q;
	logic [2:0] idx_d;
	logic [LEN_W-1:0] item_len_q;
	logic [SYM_W-1:0] item_bits_q;
	logic item_eop_q;

	logic out_free;
	logic emit;
	logic fin;
	logic e_key;
	logic [LEN_W-1:0] e_len;
	logic e_last;
	logic out_vld_q;
	logic out_key_q;
	logic [LEN_W-1:0] out_len_q;
	logic out_last_q;

	assign chars.ready = (count_q != CW'(FIFO_DEPTH));
	assign wr_en = chars.valid && chars.ready;
	assign rd_en = (count_q != '0) && (!pend_q || load);

	mce_ram #(
		.WIDTH(EW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_ptr_q),
		.wdata({chars.character, chars.end_of_phrase}),
		.re(rd_en),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	assign rd_char = rdata[EW-1:1];
	assign rd_eop = rdata[0];
	assign rd_code = mce_lookup(rd_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (rd_en) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign out_free = !out_vld_q || elements.ready;
	assign emit = (state_q != ST_IDLE) && out_free;
	assign load = pend_q && ((state_q == ST_IDLE) || fin);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		fin = 1'b0;
		e_key = 1'b0;
		e_len = LEN_SYM_GAP;
		e_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_SPACE: begin
				e_len = LEN_WORD_GAP;
				if (emit) begin
					state_d = (item_len_q != '0) ? ST_MARK : ST_LETTER;
				end
			end
			ST_MARK: begin
				e_key = 1'b1;
				e_len = item_bits_q[3'd4 - idx_q] ? LEN_DASH : LEN_DOT;
				if (emit) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				e_len = LEN_SYM_GAP;
				if (emit) begin
					idx_d = idx_q + 3'd1;
					state_d = ((idx_q + 3'd1) == item_len_q) ? ST_LETTER : ST_MARK;
				end
			end
			ST_LETTER: begin
				e_len = LEN_LETTER_GAP;
				e_last = !item_eop_q;
				if (emit) begin
					if (item_eop_q) begin
						state_d = ST_WORD;
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_WORD: begin
				e_len = LEN_WORD_GAP;
				e_last = 1'b1;
				if (emit) begin
					fin = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = ST_IDLE;
		end
		if (load) begin
			idx_d = '0;
			if (rd_char == CHAR_SPACE) begin
				state_d = ST_SPACE;
			end else if (rd_code.len != '0) begin
				state_d = ST_MARK;
			end else begin
				state_d = ST_LETTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_len_q <= rd_code.len;
			item_bits_q <= rd_code.bits;
			item_eop_q <= rd_eop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (elements.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_key_q <= e_key;
			out_len_q <= e_len;
			out_last_q <= e_last;
		end
	end

	assign elements.valid = out_vld_q;
	assign elements.key_down = out_key_q;
	assign elements.length_units = out_len_q;
	assign elements.last_of_run = out_last_q;

endmodule

FILE: design/mce_checker.sv
`timescale 1ns / 1ps
// Port checker of the Morse character encoder and the bind that attaches it
// to the top level. Depends on mce_pkg and morse_character_encoder_unit.
module mce_checker import mce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic key_down,
	input logic [LEN_W-1:0] length_units,
	input logic last_of_run
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("element valid dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(key_down) && $stable(length_units) && $stable(last_of_run))
		else $error("element payload changed while stalled");

	a_mark_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_down |-> (length_units == LEN_DOT || length_units == LEN_DASH))
		else $error("mark with a length other than dot or dash");

	a_mark_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_down |-> !last_of_run)
		else $error("a character ended on a mark");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |->
		(length_units == LEN_LETTER_GAP || length_units == LEN_WORD_GAP))
		else $error("last element of a character is not a letter or word gap");

endmodule

bind morse_character_encoder_unit mce_checker u_mce_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(elements.valid),
	.out_ready(elements.ready),
	.key_down(elements.key_down),
	.length_units(elements.length_units),
	.last_of_run(elements.last_of_run)
);
